// ----- design/ftfm_pkg.sv -----
// shared types and constants for the five-tuple first-match filter
// used by ftfm_cell, five_tuple_first_match_filter_core, ftfm_assertions and the testbench
// no dependencies
package ftfm_pkg;

    localparam int MAX_RULES = 64;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);
    localparam int HIDX_W    = 6;

    localparam logic [15:0] ETHTYPE_ARP = 16'h0806;
    localparam logic [15:0] ETHTYPE_STP = 16'h0026;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;

    typedef enum logic [1:0] {
        KIND_CLEAR    = 2'd0,
        KIND_APPEND   = 2'd1,
        KIND_CLASSIFY = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
    } rule_t;

    typedef struct packed {
        logic  en;
        rule_t rule;
    } rule_wr_t;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
        logic        use_ports;
    } key_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [HIDX_W-1:0] idx;
    } tok_t;

endpackage

// ----- design/ftfm_cell.sv -----
// one rule cell of the filter chain: holds a rule and passes the match token on
// depends on ftfm_pkg
module ftfm_cell
    import ftfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  cell_pos,
    input  logic [HIDX_W-1:0] cell_tag,
    input  logic [CNT_W-1:0]  rule_count,
    input  rule_wr_t          wr,
    input  key_t              key,
    input  tok_t              tok_in,
    output tok_t              tok_out
);

    rule_t rule_reg;
    tok_t  tok_reg;
    tok_t  tok_next;
    logic  in_use;
    logic  ok_proto;
    logic  ok_src;
    logic  ok_dst;
    logic  ok_sport;
    logic  ok_dport;
    logic  match;

    assign in_use   = cell_pos < rule_count;
    assign ok_proto = (rule_reg.protocol == '0) || (rule_reg.protocol == key.protocol);
    assign ok_src   = (rule_reg.src_addr == '0) || (rule_reg.src_addr == key.src_addr);
    assign ok_dst   = (rule_reg.dst_addr == '0) || (rule_reg.dst_addr == key.dst_addr);
    assign ok_sport = (rule_reg.l4_sport == '0) || (rule_reg.l4_sport == key.l4_sport);
    assign ok_dport = (rule_reg.l4_dport == '0) || (rule_reg.l4_dport == key.l4_dport);
    assign match    = ok_proto && ok_src && ok_dst
                      && (!key.use_ports || (ok_sport && ok_dport));

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.hit && in_use && match)
        begin
            tok_next.hit = 1'b1;
            tok_next.idx = cell_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (cell_pos == rule_count))
        begin
            rule_reg <= wr.rule;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- design/five_tuple_first_match_filter_core.sv -----
// top level of the five-tuple first-match filter: control, rule count, result register
// depends on ftfm_pkg and ftfm_cell
//
// One transaction at a time. Clear, append, unused kinds and ARP/STP frames put
// their result in the output register in the cycle after acceptance. A classify
// sends a match token from the inject register down the chain of MAX_RULES rule
// cells, one cell per cycle; the token that leaves the last cell is registered
// as the result. A new transaction is taken once the previous one is finished
// and its result is taken or being taken.
module five_tuple_first_match_filter_core
    import ftfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic              action,
    input  logic [15:0]       ethertype,
    input  logic [7:0]        protocol,
    input  logic [31:0]       src_addr,
    input  logic [31:0]       dst_addr,
    input  logic [15:0]       l4_sport,
    input  logic [15:0]       l4_dport,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              verdict,
    output logic              hit,
    output logic [HIDX_W-1:0] hit_index,
    output logic              table_full
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  rule_count_reg, rule_count_next;
    logic              last_action_reg, last_action_next;
    tok_t              inj_reg, inj_next;
    logic              out_valid_reg, out_valid_next;
    logic              verdict_reg, verdict_next;
    logic              hit_reg, hit_next;
    logic [HIDX_W-1:0] hit_index_reg, hit_index_next;
    logic              table_full_reg, table_full_next;
    key_t              key_reg;
    rule_wr_t          wr;
    logic              accept;
    tok_t              tok [0:MAX_RULES];

    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next       = state_reg;
        rule_count_next  = rule_count_reg;
        last_action_next = last_action_reg;
        inj_next         = '0;
        out_valid_next   = out_valid_reg && out_stall;
        verdict_next     = verdict_reg;
        hit_next         = hit_reg;
        hit_index_next   = hit_index_reg;
        table_full_next  = table_full_reg;
        wr.en            = 1'b0;
        wr.rule.protocol = protocol;
        wr.rule.src_addr = src_addr;
        wr.rule.dst_addr = dst_addr;
        wr.rule.l4_sport = l4_sport;
        wr.rule.l4_dport = l4_dport;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    verdict_next    = 1'b0;
                    hit_next        = 1'b0;
                    hit_index_next  = '0;
                    table_full_next = 1'b0;
                    out_valid_next  = 1'b1;
                    case (kind)
                        KIND_CLEAR:
                        begin
                            rule_count_next  = '0;
                            last_action_next = 1'b0;
                        end
                        KIND_APPEND:
                        begin
                            if (rule_count_reg == CNT_W'(MAX_RULES))
                            begin
                                table_full_next = 1'b1;
                            end
                            else
                            begin
                                wr.en            = 1'b1;
                                rule_count_next  = rule_count_reg + CNT_W'(1);
                                last_action_next = action;
                            end
                        end
                        KIND_CLASSIFY:
                        begin
                            if (!(ethertype inside {ETHTYPE_ARP, ETHTYPE_STP}))
                            begin
                                out_valid_next = 1'b0;
                                inj_next.valid = 1'b1;
                                state_next     = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (tok[MAX_RULES].valid)
                begin
                    out_valid_next  = 1'b1;
                    hit_next        = tok[MAX_RULES].hit;
                    hit_index_next  = tok[MAX_RULES].idx;
                    verdict_next    = tok[MAX_RULES].hit ? last_action_reg : !last_action_reg;
                    table_full_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rule_count_reg  <= '0;
            last_action_reg <= 1'b0;
            inj_reg         <= '0;
            out_valid_reg   <= 1'b0;
            verdict_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            hit_index_reg   <= '0;
            table_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rule_count_reg  <= rule_count_next;
            last_action_reg <= last_action_next;
            inj_reg         <= inj_next;
            out_valid_reg   <= out_valid_next;
            verdict_reg     <= verdict_next;
            hit_reg         <= hit_next;
            hit_index_reg   <= hit_index_next;
            table_full_reg  <= table_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg.protocol  <= protocol;
            key_reg.src_addr  <= src_addr;
            key_reg.dst_addr  <= dst_addr;
            key_reg.l4_sport  <= l4_sport;
            key_reg.l4_dport  <= l4_dport;
            key_reg.use_ports <= protocol inside {PROTO_TCP, PROTO_UDP};
        end
    end

    assign tok[0] = inj_reg;

    for (genvar i = 0; i < MAX_RULES; i++)
    begin : g_cell
        ftfm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_pos   (CNT_W'(i)),
            .cell_tag   (HIDX_W'(i % 64)),
            .rule_count (rule_count_reg),
            .wr         (wr),
            .key        (key_reg),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1])
        );
    end

    assign out_valid  = out_valid_reg;
    assign verdict    = verdict_reg;
    assign hit        = hit_reg;
    assign hit_index  = hit_index_reg;
    assign table_full = table_full_reg;

endmodule

// ----- design/ftfm_checker.sv -----
// port-level checks for five_tuple_first_match_filter_core, attached by bind
// depends on ftfm_pkg and the top-level port list
module ftfm_assertions
    import ftfm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [1:0]        kind,
    input logic              out_valid,
    input logic              out_stall,
    input logic              verdict,
    input logic              hit,
    input logic [HIDX_W-1:0] hit_index,
    input logic              table_full
);

    // held result stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // non-classify transactions answer in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind != KIND_CLASSIFY) |=> out_valid)
        else $error("missing result after non-classify transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> !hit && !verdict && (hit_index == '0))
        else $error("table full result carries classify fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (hit_index == '0))
        else $error("hit index set without a hit");

endmodule

bind five_tuple_first_match_filter_core ftfm_assertions u_ftfm_assertions (.*);

// ----- verif/ftfm_checker.sv -----
// checker for the five-tuple first-match filter: watches both channels, predicts, compares
// depends on ftfm_pkg; hands its mismatch count and open expectations to the testbench top
module ftfm_checker
    import ftfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        kind,
    input  logic              action,
    input  logic [15:0]       ethertype,
    input  logic [7:0]        protocol,
    input  logic [31:0]       src_addr,
    input  logic [31:0]       dst_addr,
    input  logic [15:0]       l4_sport,
    input  logic [15:0]       l4_dport,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              verdict,
    input  logic              hit,
    input  logic [HIDX_W-1:0] hit_index,
    input  logic              table_full,
    output int                mismatches,
    output int                outstanding
);

    typedef struct packed {
        logic              verdict;
        logic              hit;
        logic [HIDX_W-1:0] hit_index;
        logic              table_full;
    } filter_result_t;

    logic           rule_act_mem [MAX_RULES];
    rule_t          rule_mem [MAX_RULES];
    int             rule_total;
    filter_result_t expected_results [$];

    function automatic logic field_matches(logic [31:0] rule_val, logic [31:0] pkt_val);
        return rule_val == '0 || rule_val == pkt_val;
    endfunction

    // applies the accepted transaction to the shadow table and returns its result
    function automatic filter_result_t filter_predict();
        filter_result_t res;
        logic           last_act;
        logic           ports_on;
        int             i;
        res = '0;
        case (kind)
            KIND_CLEAR:
                rule_total = 0;
            KIND_APPEND:
                if (rule_total >= MAX_RULES)
                begin
                    res.table_full = 1'b1;
                end
                else
                begin
                    rule_act_mem[rule_total] = action;
                    rule_mem[rule_total] = '{protocol, src_addr, dst_addr, l4_sport, l4_dport};
                    rule_total++;
                end
            KIND_CLASSIFY:
                if (!(ethertype inside {ETHTYPE_ARP, ETHTYPE_STP}))
                begin
                    last_act = (rule_total > 0) ? rule_act_mem[rule_total - 1] : 1'b0;
                    ports_on = protocol inside {PROTO_TCP, PROTO_UDP};
                    res.verdict = ~last_act;
                    for (i = 0; i < rule_total && !res.hit; i++)
                    begin
                        if (field_matches(rule_mem[i].src_addr, src_addr)
                            && field_matches(rule_mem[i].dst_addr, dst_addr)
                            && field_matches(rule_mem[i].protocol, protocol)
                            && (!ports_on
                                || (field_matches(rule_mem[i].l4_sport, l4_sport)
                                    && field_matches(rule_mem[i].l4_dport, l4_dport))))
                        begin
                            res.verdict = last_act;
                            res.hit = 1'b1;
                            res.hit_index = HIDX_W'(i);
                        end
                    end
                end
            default: ;
        endcase
        return res;
    endfunction

    initial
    begin
        mismatches = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        filter_result_t want;
        if (!rst_n)
        begin
            rule_total = 0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: verdict %0d hit %0d hit_index %0d table_full %0d",
                           verdict, hit, hit_index, table_full);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (verdict !== want.verdict)
                    begin
                        $error("verdict: expected %0d, got %0d", want.verdict, verdict);
                        mismatches++;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        mismatches++;
                    end
                    if (hit_index !== want.hit_index)
                    begin
                        $error("hit_index: expected %0d, got %0d", want.hit_index, hit_index);
                        mismatches++;
                    end
                    if (table_full !== want.table_full)
                    begin
                        $error("table_full: expected %0d, got %0d", want.table_full,
                               table_full);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(filter_predict());
        end
        outstanding = expected_results.size();
    end

endmodule

// ----- verif/tb_five_tuple_first_match_filter_core.sv -----
// testbench top for five_tuple_first_match_filter_core: clock, reset, stimulus, verdict
// depends on ftfm_pkg, the core and ftfm_checker, which does all prediction and comparison
module tb_five_tuple_first_match_filter_core;
    import ftfm_pkg::*;

    localparam int          RST_CYCLES   = 6;
    localparam int          RANDOM_ITEMS = 1600;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          IDLE_LIMIT   = 4000;
    localparam int          DRAIN_CYCLES = 80;
    localparam logic [1:0]  KIND_UNUSED  = 2'd3;
    localparam logic [15:0] ETHTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP   = 8'd1;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        kind;
    logic              action;
    logic [15:0]       ethertype;
    logic [7:0]        protocol;
    logic [31:0]       src_addr;
    logic [31:0]       dst_addr;
    logic [15:0]       l4_sport;
    logic [15:0]       l4_dport;
    logic              out_valid;
    logic              out_stall;
    logic              verdict;
    logic              hit;
    logic [HIDX_W-1:0] hit_index;
    logic              table_full;

    int    mismatches;
    int    outstanding;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    item_total     = 0;
    logic  hold_req       = 1'b0;
    rule_t loaded_rules [$];

    five_tuple_first_match_filter_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .action     (action),
        .ethertype  (ethertype),
        .protocol   (protocol),
        .src_addr   (src_addr),
        .dst_addr   (dst_addr),
        .l4_sport   (l4_sport),
        .l4_dport   (l4_dport),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .verdict    (verdict),
        .hit        (hit),
        .hit_index  (hit_index),
        .table_full (table_full)
    );

    ftfm_checker filter_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .action      (action),
        .ethertype   (ethertype),
        .protocol    (protocol),
        .src_addr    (src_addr),
        .dst_addr    (dst_addr),
        .l4_sport    (l4_sport),
        .l4_dport    (l4_dport),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .verdict     (verdict),
        .hit         (hit),
        .hit_index   (hit_index),
        .table_full  (table_full),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_five_tuple_first_match_filter_core: done, errors");
        $finish;
    end

    task automatic send_item(logic [1:0] k, logic act, logic [15:0] et, logic [7:0] pr,
                             logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                             logic [15:0] dp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        kind      <= k;
        action    <= act;
        ethertype <= et;
        protocol  <= pr;
        src_addr  <= sa;
        dst_addr  <= da;
        l4_sport  <= sp;
        l4_dport  <= dp;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        if (k != KIND_UNUSED)
            item_total++;
    endtask

    task automatic clear_table();
        send_item(KIND_CLEAR, 1'($urandom), 16'($urandom), 8'($urandom), $urandom, $urandom,
                  16'($urandom), 16'($urandom));
        loaded_rules.delete();
    endtask

    task automatic add_rule(logic act, rule_t r);
        send_item(KIND_APPEND, act, 16'($urandom), r.protocol, r.src_addr, r.dst_addr,
                  r.l4_sport, r.l4_dport);
        if (loaded_rules.size() < MAX_RULES)
            loaded_rules.push_back(r);
    endtask

    task automatic classify(logic [15:0] et, logic [7:0] pr, logic [31:0] sa,
                            logic [31:0] da, logic [15:0] sp, logic [15:0] dp);
        send_item(KIND_CLASSIFY, 1'($urandom), et, pr, sa, da, sp, dp);
    endtask

    function automatic logic [7:0] pick_proto(int wild_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < wild_pct)
            return 8'd0;
        case ($urandom_range(4))
            0, 1:    return PROTO_TCP;
            2:       return PROTO_UDP;
            3:       return PROTO_ICMP;
            default: return 8'($urandom);
        endcase
    endfunction

    // small pools so that rules and packets collide often
    function automatic logic [31:0] pick_addr(int wild_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < wild_pct)
            return '0;
        if (roll < wild_pct + (100 - wild_pct) / 2)
            return 32'h0A00_0000 | $urandom_range(3);
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_port(int wild_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < wild_pct)
            return '0;
        if (roll < wild_pct + (100 - wild_pct) / 2)
            return 16'(80 + $urandom_range(2));
        return 16'($urandom);
    endfunction

    function automatic rule_t random_rule(bit specific);
        rule_t r;
        if (specific)
            r = '{pick_proto(0), $urandom, $urandom, 16'($urandom), 16'($urandom)};
        else
            r = '{pick_proto(30), pick_addr(35), pick_addr(35), pick_port(40), pick_port(40)};
        return r;
    endfunction

    // packet aimed at a loaded rule, sometimes disturbed, sometimes fully random
    task automatic probe_rules();
        rule_t       r;
        logic [15:0] et;
        int          roll;
        if (loaded_rules.size() == 0 || $urandom_range(9) == 0)
        begin
            r = '{pick_proto(0), $urandom, $urandom, 16'($urandom), 16'($urandom)};
        end
        else
        begin
            r = loaded_rules[$urandom_range(loaded_rules.size() - 1)];
            if (r.protocol == 0) r.protocol = pick_proto(0);
            if (r.src_addr == 0) r.src_addr = pick_addr(0);
            if (r.dst_addr == 0) r.dst_addr = pick_addr(0);
            if (r.l4_sport == 0) r.l4_sport = pick_port(0);
            if (r.l4_dport == 0) r.l4_dport = pick_port(0);
            if ($urandom_range(4) == 0)
            begin
                case ($urandom_range(4))
                    0:       r.protocol = r.protocol ^ 8'(1 << $urandom_range(7));
                    1:       r.src_addr = r.src_addr ^ (32'd1 << $urandom_range(31));
                    2:       r.dst_addr = r.dst_addr ^ (32'd1 << $urandom_range(31));
                    3:       r.l4_sport = r.l4_sport ^ 16'(1 << $urandom_range(15));
                    default: r.l4_dport = r.l4_dport ^ 16'(1 << $urandom_range(15));
                endcase
            end
        end
        roll = $urandom_range(99);
        if (roll < 80)
            et = ETHTYPE_IPV4;
        else if (roll < 85)
            et = ETHTYPE_ARP;
        else if (roll < 90)
            et = ETHTYPE_STP;
        else
            et = 16'($urandom);
        classify(et, r.protocol, r.src_addr, r.dst_addr, r.l4_sport, r.l4_dport);
    endtask

    initial
    begin
        int  phase;
        int  roll;
        int  n;
        bit  pressure_done;
        pressure_done = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_CLEAR;
        action    = 1'b0;
        ethertype = '0;
        protocol  = '0;
        src_addr  = '0;
        dst_addr  = '0;
        l4_sport  = '0;
        l4_dport  = '0;
        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty table, arp/stp, unused kind, wildcards, port rules
        clear_table();
        classify(ETHTYPE_IPV4, PROTO_TCP, 32'd1, 32'd2, 16'd3, 16'd4);
        classify(ETHTYPE_ARP, PROTO_TCP, 32'd1, 32'd2, 16'd3, 16'd4);
        classify(ETHTYPE_STP, PROTO_UDP, 32'd1, 32'd2, 16'd3, 16'd4);
        send_item(KIND_UNUSED, 1'b1, 16'hFFFF, 8'hFF, '1, '1, '1, '1);
        add_rule(1'b0, '{PROTO_TCP, 32'hFFFF_FFFF, 32'd1, 16'hFFFF, 16'd1});
        add_rule(1'b1, '{PROTO_UDP, 32'd0, 32'd0, 16'd0, 16'h8000});
        classify(ETHTYPE_IPV4, PROTO_TCP, 32'hFFFF_FFFF, 32'd1, 16'hFFFF, 16'd1);
        classify(16'hFFFF, PROTO_UDP, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h8000);
        classify(16'h0000, PROTO_ICMP, 32'hFFFF_FFFF, 32'd1, 16'hFFFF, 16'd1);
        classify(ETHTYPE_IPV4, PROTO_TCP, 32'hFFFF_FFFF, 32'd1, 16'hFFFF, 16'd2);
        add_rule(1'b0, '{PROTO_ICMP, 32'd0, 32'd0, 16'd5, 16'd7});
        classify(ETHTYPE_IPV4, PROTO_ICMP, 32'h1234_5678, 32'h9ABC_DEF0, 16'd0, 16'd0);
        classify(ETHTYPE_IPV4, 8'hFF, 32'h1234_5678, 32'h9ABC_DEF0, 16'd5, 16'd7);
        classify(ETHTYPE_ARP, PROTO_ICMP, 32'h1234_5678, 32'h9ABC_DEF0, 16'd0, 16'd0);
        add_rule(1'b1, '0);
        classify(ETHTYPE_IPV4, 8'hFF, '1, '1, '1, '1);
        clear_table();
        classify(ETHTYPE_IPV4, PROTO_UDP, 32'd0, 32'd0, 16'd0, 16'd0);

        item_total = 0;
        while (item_total < RANDOM_ITEMS)
        begin
            phase = item_total * 4 / RANDOM_ITEMS;
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default:
                begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
            endcase
            if (phase == 2 && !pressure_done)
            begin
                pressure_done = 1'b1;
                hold_req = 1'b1;
                repeat (12) probe_rules();
            end
            roll = $urandom_range(99);
            if (roll < 10)
            begin
                // noise: any kind with fully random fields
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    case (2'($urandom))
                        KIND_CLEAR:  clear_table();
                        KIND_APPEND: add_rule(1'($urandom), '{8'($urandom), $urandom,
                                              $urandom, 16'($urandom), 16'($urandom)});
                        KIND_CLASSIFY: classify(16'($urandom), 8'($urandom), $urandom,
                                                $urandom, 16'($urandom), 16'($urandom));
                        default: send_item(KIND_UNUSED, 1'($urandom), 16'($urandom),
                                           8'($urandom), $urandom, $urandom, 16'($urandom),
                                           16'($urandom));
                    endcase
                end
            end
            else if (roll < 25)
            begin
                // fill to near the top, or past it, with specific rules
                clear_table();
                n = $urandom_range(MAX_RULES - 4, MAX_RULES + 6);
                repeat (n) add_rule(1'($urandom), random_rule(1'b1));
                repeat (10) probe_rules();
            end
            else
            begin
                if ($urandom_range(3) == 0)
                    clear_table();
                n = $urandom_range(1, 8);
                repeat (n) add_rule(1'($urandom), random_rule(1'b0));
                n = $urandom_range(2, 10);
                repeat (n) probe_rules();
            end
        end

        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb_five_tuple_first_match_filter_core: done, clean");
        else
            $display("tb_five_tuple_first_match_filter_core: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ftfm_pkg.sv
design/ftfm_cell.sv
design/five_tuple_first_match_filter_core.sv
design/ftfm_checker.sv
verif/ftfm_checker.sv
verif/tb_five_tuple_first_match_filter_core.sv
